### rtl/lms_pkg.sv
// Shared types and constants of the LMS adaptive FIR filter.
package lms_pkg;

  localparam int OP_W     = 2;
  localparam int SAMPLE_W = 16;
  localparam int WEIGHT_W = 24;
  localparam int GAIN_W   = 15;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 31;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Fixed-point shifts: error back to Q1.15, update term back to Q4.20
  localparam int ERR_SHIFT = 20;
  localparam int UPD_SHIFT = 24;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [OP_W-1:0] OP_FILTER = 2'd0;
  localparam logic [OP_W-1:0] OP_ADAPT  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic REG_STEP_GAIN = 1'b0;

  localparam logic [GAIN_W-1:0] STEP_GAIN_RESET = 15'd16384;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PUSH,
    ST_MAC,
    ST_ERR,
    ST_SAT,
    ST_GAIN,
    ST_GLAT,
    ST_UPD,
    ST_DONE
  } lms_state_t;

endpackage

### rtl/lms_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module lms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/lms_mul.sv
// Shared signed multiplier with a registered product.
module lms_mul (
  input  logic                                clk,
  input  logic signed [lms_pkg::MUL_A_W-1:0] a,
  input  logic signed [lms_pkg::MUL_B_W-1:0] b,
  output logic signed [lms_pkg::MUL_P_W-1:0] p_r
);

  logic signed [lms_pkg::MUL_P_W-1:0] p_nxt;

  always_comb begin
    p_nxt = lms_pkg::MUL_P_W'(a) * lms_pkg::MUL_P_W'(b);
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

### rtl/lms_adaptive_fir.sv
// LMS adaptive FIR filter top level: sequencer, accumulator and tap memories.
//
// Input channel (in_valid/in_ready): op, sample and desired per item. Output
// channel (out_valid/out_ready): one error value per item, held in an output
// register, so the next item is taken while a result still waits.
// Configuration: APB-style write of step_gain at byte address 0, no wait states.
//
// One item is in flight at a time; in_ready is high only in the idle state.
// All taps go through one shared multiplier and one read port per array,
// one tap per cycle. What each op does:
//   op 0 (and 3): one pass over the taps
//   op 1:         estimate pass plus update pass
//   op 2:         zero both arrays, entry by entry
// The block returns to the idle state before it takes the next item.
//
// After reset the block sweeps both arrays to zero, entry by entry, and holds
// in_ready low meanwhile; step_gain returns to 1.0. If the receiver stalls,
// the finished result waits in the output register and a following result
// waits in the sequencer until the register frees up.
module lms_adaptive_fir #(
  parameter int TAPS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [lms_pkg::OP_W-1:0]              in_op,
  input  logic signed [lms_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic signed [lms_pkg::SAMPLE_W-1:0]   in_desired,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [lms_pkg::SAMPLE_W-1:0]   out_error,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [lms_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [lms_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [lms_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready
);

  localparam int PTR_W = $clog2(TAPS);
  localparam int CNT_W = $clog2(TAPS + 1);
  localparam int ACC_W = 41 + PTR_W;
  localparam int SW    = lms_pkg::SAMPLE_W;
  localparam int WW    = lms_pkg::WEIGHT_W;
  localparam int PW    = lms_pkg::MUL_P_W;
  localparam int DW    = PW - lms_pkg::UPD_SHIFT;

  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(TAPS - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TAPS);

  localparam logic signed [ACC_W-1:0] ERR_RND = ACC_W'(1) <<< (lms_pkg::ERR_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] ERR_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] ERR_MIN = -ACC_W'(32768);
  localparam logic signed [PW-1:0]    UPD_RND = PW'(1) <<< (lms_pkg::UPD_SHIFT - 1);
  localparam logic signed [WW:0]      W_MAX   = (WW + 1)'((1 <<< (WW - 1)) - 1);
  localparam logic signed [WW:0]      W_MIN   = -(WW + 1)'(1 <<< (WW - 1));

  lms_pkg::lms_state_t state_r, state_nxt;

  logic [lms_pkg::GAIN_W-1:0]        step_gain_r, step_gain_nxt;
  logic [PTR_W-1:0]                  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]                  k_r, k_nxt;
  logic [PTR_W-1:0]                  idx_r, idx_nxt;
  logic                              rd_v_r, rd_v_nxt;
  logic                              mul_v_r, mul_v_nxt;
  logic                              clr_res_r, clr_res_nxt;
  logic                              out_valid_r, out_valid_nxt;

  logic [lms_pkg::OP_W-1:0]          op_r, op_nxt;
  logic signed [SW-1:0]              sample_r, sample_nxt;
  logic signed [SW-1:0]              desired_r, desired_nxt;
  logic signed [ACC_W-1:0]           acc_r, acc_nxt;
  logic signed [SW-1:0]              err_r, err_nxt;
  logic signed [lms_pkg::MUL_A_W-1:0] ge_r, ge_nxt;
  logic [PTR_W-1:0]                  rk_r, rk_nxt;
  logic [PTR_W-1:0]                  mk_r, mk_nxt;
  logic signed [WW-1:0]              w_hold_r, w_hold_nxt;
  logic signed [SW-1:0]              out_error_r, out_error_nxt;

  logic                              h_we, w_we;
  logic [PTR_W-1:0]                  h_waddr, w_waddr;
  logic [SW-1:0]                     h_wdata;
  logic [WW-1:0]                     w_wdata;
  logic [SW-1:0]                     h_rdata;
  logic [WW-1:0]                     w_rdata;

  logic signed [lms_pkg::MUL_A_W-1:0] mul_a;
  logic signed [lms_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0]               mul_p;

  logic [PTR_W-1:0]                  newest;
  logic                              cfg_wr;
  logic signed [ACC_W-1:0]           err_shr;
  logic signed [PW-1:0]              upd_rnd;
  logic signed [DW-1:0]              delta;
  logic signed [WW:0]                w_sum;

  lms_ram #(.WIDTH(SW), .DEPTH(TAPS)) u_hist_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (idx_r),
    .rdata (h_rdata)
  );

  lms_ram #(.WIDTH(WW), .DEPTH(TAPS)) u_wgt_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (k_r[PTR_W-1:0]),
    .rdata (w_rdata)
  );

  lms_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  assign in_ready  = (state_r == lms_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_error = out_error_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    if (paddr[2] == lms_pkg::REG_STEP_GAIN) begin
      prdata = lms_pkg::APB_DATA_W'(step_gain_r);
    end
  end

  always_comb begin
    newest  = (ptr_r == '0) ? LAST_IDX : ptr_r - PTR_W'(1);
    err_shr = acc_r >>> lms_pkg::ERR_SHIFT;
    upd_rnd = mul_p + UPD_RND;
    delta   = upd_rnd[PW-1:lms_pkg::UPD_SHIFT];
    w_sum   = (WW + 1)'(w_hold_r) + (WW + 1)'(delta);
  end

  always_comb begin
    state_nxt     = state_r;
    step_gain_nxt = step_gain_r;
    ptr_nxt       = ptr_r;
    k_nxt         = k_r;
    idx_nxt       = idx_r;
    rd_v_nxt      = 1'b0;
    mul_v_nxt     = 1'b0;
    clr_res_nxt   = clr_res_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    op_nxt        = op_r;
    sample_nxt    = sample_r;
    desired_nxt   = desired_r;
    acc_nxt       = acc_r;
    err_nxt       = err_r;
    ge_nxt        = ge_r;
    rk_nxt        = k_r[PTR_W-1:0];
    mk_nxt        = rk_r;
    w_hold_nxt    = $signed(w_rdata);
    out_error_nxt = out_error_r;
    h_we          = 1'b0;
    h_waddr       = newest;
    h_wdata       = sample_r;
    w_we          = 1'b0;
    w_waddr       = mk_r;
    w_wdata       = w_sum[WW-1:0];
    mul_a         = lms_pkg::MUL_A_W'($signed(w_rdata));
    mul_b         = $signed(h_rdata);

    if (cfg_wr && paddr[2] == lms_pkg::REG_STEP_GAIN) begin
      step_gain_nxt = pwdata[lms_pkg::GAIN_W-1:0];
    end

    unique case (state_r)
      lms_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_op;
          sample_nxt  = in_sample;
          desired_nxt = in_desired;
          k_nxt       = '0;
          if (in_op == lms_pkg::OP_CLEAR) begin
            clr_res_nxt = 1'b1;
            err_nxt     = '0;
            state_nxt   = lms_pkg::ST_CLEAR;
          end else begin
            state_nxt = lms_pkg::ST_PUSH;
          end
        end
      end

      lms_pkg::ST_CLEAR: begin
        h_we    = 1'b1;
        h_waddr = k_r[PTR_W-1:0];
        h_wdata = '0;
        w_we    = 1'b1;
        w_waddr = k_r[PTR_W-1:0];
        w_wdata = '0;
        k_nxt   = k_r + CNT_W'(1);
        if (k_r[PTR_W-1:0] == LAST_IDX) begin
          ptr_nxt   = '0;
          state_nxt = clr_res_r ? lms_pkg::ST_DONE : lms_pkg::ST_IDLE;
        end
      end

      lms_pkg::ST_PUSH: begin
        h_we      = 1'b1;
        ptr_nxt   = newest;
        idx_nxt   = newest;
        k_nxt     = '0;
        acc_nxt   = '0;
        state_nxt = lms_pkg::ST_MAC;
      end

      lms_pkg::ST_MAC, lms_pkg::ST_UPD: begin
        // Issue one tap read per cycle; the registered read data comes back in the next cycle.
        if (k_r != CNT_END) begin
          rd_v_nxt = 1'b1;
          k_nxt    = k_r + CNT_W'(1);
          idx_nxt  = (idx_r == LAST_IDX) ? '0 : idx_r + PTR_W'(1);
        end
        mul_v_nxt = rd_v_r;
        if (state_r == lms_pkg::ST_UPD) begin
          mul_a = ge_r;
          if (mul_v_r) begin
            w_we = 1'b1;
            if (w_sum > W_MAX) begin
              w_wdata = W_MAX[WW-1:0];
            end else if (w_sum < W_MIN) begin
              w_wdata = W_MIN[WW-1:0];
            end
          end
        end else if (mul_v_r) begin
          acc_nxt = acc_r + ACC_W'(mul_p);
        end
        if (k_r == CNT_END && !rd_v_r && !mul_v_r) begin
          state_nxt = (state_r == lms_pkg::ST_MAC) ? lms_pkg::ST_ERR : lms_pkg::ST_DONE;
        end
      end

      lms_pkg::ST_ERR: begin
        acc_nxt   = (ACC_W'(desired_r) <<< lms_pkg::ERR_SHIFT) - acc_r + ERR_RND;
        state_nxt = lms_pkg::ST_SAT;
      end

      lms_pkg::ST_SAT: begin
        if (err_shr > ERR_MAX) begin
          err_nxt = ERR_MAX[SW-1:0];
        end else if (err_shr < ERR_MIN) begin
          err_nxt = ERR_MIN[SW-1:0];
        end else begin
          err_nxt = err_shr[SW-1:0];
        end
        state_nxt = (op_r == lms_pkg::OP_ADAPT) ? lms_pkg::ST_GAIN : lms_pkg::ST_DONE;
      end

      lms_pkg::ST_GAIN: begin
        mul_a     = lms_pkg::MUL_A_W'(err_r);
        mul_b     = $signed({1'b0, step_gain_r});
        state_nxt = lms_pkg::ST_GLAT;
      end

      lms_pkg::ST_GLAT: begin
        ge_nxt    = mul_p[lms_pkg::MUL_A_W-1:0];
        k_nxt     = '0;
        idx_nxt   = ptr_r;
        state_nxt = lms_pkg::ST_UPD;
      end

      lms_pkg::ST_DONE: begin
        // Hold the result until the output register frees up.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_error_nxt = err_r;
          clr_res_nxt   = 1'b0;
          state_nxt     = lms_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lms_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lms_pkg::ST_CLEAR;
      step_gain_r <= lms_pkg::STEP_GAIN_RESET;
      ptr_r       <= '0;
      k_r         <= '0;
      idx_r       <= '0;
      rd_v_r      <= 1'b0;
      mul_v_r     <= 1'b0;
      clr_res_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_gain_r <= step_gain_nxt;
      ptr_r       <= ptr_nxt;
      k_r         <= k_nxt;
      idx_r       <= idx_nxt;
      rd_v_r      <= rd_v_nxt;
      mul_v_r     <= mul_v_nxt;
      clr_res_r   <= clr_res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    sample_r    <= sample_nxt;
    desired_r   <= desired_nxt;
    acc_r       <= acc_nxt;
    err_r       <= err_nxt;
    ge_r        <= ge_nxt;
    rk_r        <= rk_nxt;
    mk_r        <= mk_nxt;
    w_hold_r    <= w_hold_nxt;
    out_error_r <= out_error_nxt;
  end

endmodule

### dv/tb_lms_adaptive_fir.sv
// Testbench for the LMS adaptive FIR filter: directed table plus random items.
module tb_lms_adaptive_fir;

  localparam int TAPS = 64;
  localparam int IDX_W = $clog2(TAPS);
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int HANG_LIMIT = 4000;
  localparam int TAIL_CYCLES = 160;

  localparam logic [lms_pkg::OP_W-1:0] OP_UNDEF = 2'd3;
  localparam logic [lms_pkg::APB_ADDR_W-1:0] STEP_GAIN_ADDR =
      lms_pkg::APB_ADDR_W'(4 * int'(lms_pkg::REG_STEP_GAIN));

  localparam logic signed [lms_pkg::SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [lms_pkg::SAMPLE_W-1:0] S_MIN = 16'sh8000;
  localparam longint ERR_MAX = 32767;
  localparam longint ERR_MIN = -32768;
  localparam longint W_MAX = (longint'(1) <<< (lms_pkg::WEIGHT_W - 1)) - 1;
  localparam longint W_MIN = -(longint'(1) <<< (lms_pkg::WEIGHT_W - 1));

  typedef struct packed {
    logic [lms_pkg::OP_W-1:0]            op;
    logic signed [lms_pkg::SAMPLE_W-1:0] sample;
    logic signed [lms_pkg::SAMPLE_W-1:0] desired;
    logic                                typed;
    logic signed [lms_pkg::SAMPLE_W-1:0] err;
  } stim_t;

  // Rows with typed set carry an error that follows directly from zero weights.
  localparam stim_t DIRECTED [23] = '{
    '{lms_pkg::OP_FILTER, 16'sh0000, 16'sh0000, 1'b1, 16'sh0000},
    '{lms_pkg::OP_FILTER, S_MAX,     S_MAX,     1'b1, S_MAX},
    '{lms_pkg::OP_FILTER, S_MIN,     S_MIN,     1'b1, S_MIN},
    '{OP_UNDEF,           16'sh1234, 16'shFFFF, 1'b1, 16'shFFFF},
    '{lms_pkg::OP_ADAPT,  S_MAX,     S_MAX,     1'b1, S_MAX},
    '{lms_pkg::OP_ADAPT,  S_MIN,     S_MIN,     1'b0, 16'sh0000},
    '{lms_pkg::OP_ADAPT,  S_MAX,     S_MAX,     1'b0, 16'sh0000},
    '{lms_pkg::OP_ADAPT,  S_MAX,     S_MAX,     1'b0, 16'sh0000},
    '{lms_pkg::OP_ADAPT,  S_MAX,     S_MAX,     1'b0, 16'sh0000},
    '{lms_pkg::OP_ADAPT,  S_MAX,     S_MAX,     1'b0, 16'sh0000},
    '{lms_pkg::OP_ADAPT,  S_MAX,     S_MAX,     1'b0, 16'sh0000},
    '{lms_pkg::OP_ADAPT,  S_MAX,     S_MAX,     1'b0, 16'sh0000},
    '{lms_pkg::OP_FILTER, S_MAX,     S_MIN,     1'b0, 16'sh0000},
    '{lms_pkg::OP_FILTER, S_MIN,     S_MAX,     1'b0, 16'sh0000},
    '{OP_UNDEF,           16'sh5555, 16'shAAAA, 1'b0, 16'sh0000},
    '{lms_pkg::OP_ADAPT,  16'shAAAA, 16'sh5555, 1'b0, 16'sh0000},
    '{lms_pkg::OP_ADAPT,  16'shFFFF, 16'sh0001, 1'b0, 16'sh0000},
    '{lms_pkg::OP_ADAPT,  16'sh0001, 16'shFFFF, 1'b0, 16'sh0000},
    '{lms_pkg::OP_CLEAR,  S_MAX,     S_MAX,     1'b1, 16'sh0000},
    '{lms_pkg::OP_FILTER, 16'sh0064, 16'shFF38, 1'b1, 16'shFF38},
    '{lms_pkg::OP_ADAPT,  S_MIN,     16'sh0000, 1'b1, 16'sh0000},
    '{lms_pkg::OP_CLEAR,  16'sh0000, 16'sh0000, 1'b1, 16'sh0000},
    '{lms_pkg::OP_ADAPT,  16'sh4000, 16'sh2000, 1'b1, 16'sh2000}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [lms_pkg::OP_W-1:0] in_op = '0;
  logic signed [lms_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic signed [lms_pkg::SAMPLE_W-1:0] in_desired = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [lms_pkg::SAMPLE_W-1:0] out_error;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [lms_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [lms_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [lms_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  lms_adaptive_fir #(.TAPS(TAPS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_sample (in_sample),
    .in_desired(in_desired),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_error (out_error),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Filter state as the block should hold it
  logic [lms_pkg::GAIN_W-1:0] gain_model = lms_pkg::STEP_GAIN_RESET;
  logic signed [lms_pkg::SAMPLE_W-1:0] hist_model [TAPS] = '{default: '0};
  logic signed [lms_pkg::WEIGHT_W-1:0] weight_model [TAPS] = '{default: '0};
  logic [IDX_W-1:0] newest_slot = '0;

  logic signed [lms_pkg::SAMPLE_W-1:0] expected_errors [$];
  int mismatches = 0;
  int stuck_cycles = 0;
  int stall_left = 0;
  int stall_mode = 0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic predict_error(input logic [lms_pkg::OP_W-1:0] op,
                               input logic signed [lms_pkg::SAMPLE_W-1:0] smp,
                               input logic signed [lms_pkg::SAMPLE_W-1:0] dsr,
                               output logic signed [lms_pkg::SAMPLE_W-1:0] err);
    longint acc;
    longint diff;
    longint gained;
    longint upd;
    logic [IDX_W-1:0] slot;
    if (op == lms_pkg::OP_CLEAR) begin
      foreach (hist_model[k]) begin
        hist_model[k] = '0;
        weight_model[k] = '0;
      end
      newest_slot = '0;
      err = '0;
    end else begin
      // push: step the newest slot down with wrap, weight 0 pairs with it
      newest_slot = newest_slot - 1'b1;
      hist_model[newest_slot] = smp;
      acc = 0;
      slot = newest_slot;
      for (int k = 0; k < TAPS; k++) begin
        acc += longint'(weight_model[k]) * longint'(hist_model[slot]);
        slot = slot + 1'b1;
      end
      diff = (longint'(dsr) <<< lms_pkg::ERR_SHIFT) - acc;
      diff = (diff + (longint'(1) <<< (lms_pkg::ERR_SHIFT - 1))) >>> lms_pkg::ERR_SHIFT;
      diff = clamp(diff, ERR_MIN, ERR_MAX);
      err = lms_pkg::SAMPLE_W'(diff);
      if (op == lms_pkg::OP_ADAPT) begin
        gained = longint'(gain_model) * diff;
        slot = newest_slot;
        for (int k = 0; k < TAPS; k++) begin
          upd = (gained * longint'(hist_model[slot])
                 + (longint'(1) <<< (lms_pkg::UPD_SHIFT - 1))) >>> lms_pkg::UPD_SHIFT;
          weight_model[k] = lms_pkg::WEIGHT_W'(
              clamp(longint'(weight_model[k]) + upd, W_MIN, W_MAX));
          slot = slot + 1'b1;
        end
      end
    end
  endtask

  task automatic send_item(input logic [lms_pkg::OP_W-1:0] op,
                           input logic signed [lms_pkg::SAMPLE_W-1:0] smp,
                           input logic signed [lms_pkg::SAMPLE_W-1:0] dsr,
                           input logic typed,
                           input logic signed [lms_pkg::SAMPLE_W-1:0] typed_err);
    logic signed [lms_pkg::SAMPLE_W-1:0] pred;
    @(negedge clk);
    in_valid <= 1'b1;
    in_op <= op;
    in_sample <= smp;
    in_desired <= dsr;
    do @(posedge clk); while (!in_ready);
    predict_error(op, smp, dsr, pred);
    expected_errors.push_back(typed ? typed_err : pred);
  endtask

  // Hold off new items until every pending result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_errors.size() != 0) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [lms_pkg::APB_DATA_W-1:0] wdata,
                            output logic [lms_pkg::APB_DATA_W-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= STEP_GAIN_ADDR;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_step_gain(input logic [lms_pkg::GAIN_W-1:0] value);
    logic [lms_pkg::APB_DATA_W-1:0] rd;
    apb_access(1'b1, lms_pkg::APB_DATA_W'(value), rd);
    gain_model = value;
    apb_access(1'b0, '0, rd);
    if (rd[lms_pkg::GAIN_W-1:0] !== value)
      report_mismatch($sformatf("step_gain read back %0d, want %0d",
                                rd[lms_pkg::GAIN_W-1:0], value));
  endtask

  function automatic logic signed [lms_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      2, 3: return lms_pkg::SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
      default: return lms_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  // Receiver: segments of always-ready, random-ready and full stall
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(1, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin : check_errors
    logic signed [lms_pkg::SAMPLE_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_errors.size() == 0) begin
        report_mismatch($sformatf("error %0d with no item pending", out_error));
      end else begin
        want = expected_errors.pop_front();
        if (out_error !== want)
          report_mismatch($sformatf("error got %0d, want %0d", out_error, want));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= HANG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", HANG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int burst_left;
    int gap;
    int pick;
    logic [lms_pkg::GAIN_W-1:0] phase_gain [PHASES];
    logic [lms_pkg::OP_W-1:0] op;
    logic signed [lms_pkg::SAMPLE_W-1:0] smp;
    logic signed [lms_pkg::SAMPLE_W-1:0] dsr;
    logic signed [lms_pkg::SAMPLE_W-1:0] prev_smp;

    phase_gain = '{15'd0, 15'd32767, 15'd1,
                   lms_pkg::GAIN_W'($urandom_range(2, 32766)), 15'd512,
                   lms_pkg::STEP_GAIN_RESET};
    prev_smp = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // wait out the clearing sweep after reset
    do @(posedge clk); while (!in_ready);

    // directed rows run at the reset gain
    foreach (DIRECTED[i])
      send_item(DIRECTED[i].op, DIRECTED[i].sample, DIRECTED[i].desired, DIRECTED[i].typed,
                DIRECTED[i].err);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      write_step_gain(phase_gain[p]);
      burst_left = 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 10);
          if (gap != 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
          end
        end
        burst_left--;
        if ($urandom_range(0, 59) == 0) drain_results();

        pick = $urandom_range(0, 199);
        if (pick < 144) op = lms_pkg::OP_ADAPT;
        else if (pick < 180) op = lms_pkg::OP_FILTER;
        else if (pick < 196) op = OP_UNDEF;
        else op = lms_pkg::OP_CLEAR;
        smp = rand_sample();
        // track a fixed two-tap system now and then so the weights converge
        if ($urandom_range(0, 3) == 0)
          dsr = lms_pkg::SAMPLE_W'((int'(smp) >>> 1) - (int'(prev_smp) >>> 2)
                                   + int'($urandom_range(0, 63)) - 32);
        else
          dsr = rand_sample();
        send_item(op, smp, dsr, 1'b0, '0);
        prev_smp = smp;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
